>>> hw/rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants
// Fixed field widths, multiplier limb size and quotient width for the
// curvature core.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int IN_W    = 43;            // coordinate width
    localparam int MAG_W   = 43;            // |coordinate difference|
    localparam int PR_W    = 2 * MAG_W;     // one square or cross term
    localparam int SQ_W    = PR_W + 1;      // squared side length
    localparam int CR_W    = PR_W + 1;      // |cross product|
    localparam int DEN_W   = 3 * SQ_W;      // product of squared sides
    localparam int CRSQ_W  = 2 * CR_W;      // cross product squared
    localparam int QB      = 33;            // root bits, one spare above 32
    localparam int OUT_W   = 32;
    localparam int LIMB_W  = 32;            // multiplier partial product limb

    localparam logic [QB-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [QB-1:0] LIM_NEG = 33'h0_8000_0000;

    typedef struct packed {
        logic neg;      // cross product negative
        logic deg;      // a side has zero length
        logic crz;      // cross product zero
    } cpc_flags_t;

endpackage

>>> hw/rtl/three_point_curvature_core.sv
// ----------------------------------------------------------------------------
// three_point_curvature_core: signed Menger curvature of three points
// Fully pipelined; a word of three points in, a curvature word out.
// ----------------------------------------------------------------------------
// Takes one word of three planar points per clock while in_stall is low and
// returns the signed curvature 4*S/(A*B*C) scaled by 2^CURV_FRAC_BITS,
// truncated toward zero, left turn positive, clamped to 32 bits (saturated
// set) and zero with degenerate set when two points coincide. Throughput is
// one word per cycle while not stalled; the pipe is built from the 2+2+2
// stages of limb multipliers and the row of 33 root cells, one per quotient
// bit. The whole pipe advances together; a two-word output buffer lets it
// keep running while one result waits, and in_stall rises only once that
// buffer is full. Only valid bits are reset; no state is kept between words.
module three_point_curvature_core import cpc_pkg::*; #(
    parameter int COORD_FRAC_BITS = 10,
    parameter int CURV_FRAC_BITS  = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  first_x,
    input  logic signed [IN_W-1:0]  first_y,
    input  logic signed [IN_W-1:0]  second_x,
    input  logic signed [IN_W-1:0]  second_y,
    input  logic signed [IN_W-1:0]  third_x,
    input  logic signed [IN_W-1:0]  third_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] curvature,
    output logic                    degenerate,
    output logic                    saturated
);

    // num = cross^2 * 2^SH, compared against q^2 * den in the cells
    localparam int SH    = 2 + 2 * (COORD_FRAC_BITS + CURV_FRAC_BITS);
    localparam int NUM_W = CRSQ_W + SH;
    localparam int CW    = ((NUM_W > DEN_W + 2 * QB) ? NUM_W : DEN_W + 2 * QB) + 1;
    // input reg, diff, 2 mul, sums, abs, 2 mul, 2 mul, cells, final
    localparam int NSTG  = 10 + QB + 1;

    function automatic logic [MAG_W-1:0] mag_of(input logic [IN_W:0] d);
        logic [IN_W:0] n;
        n = -d;
        return d[IN_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // pipeline control
    logic            adv;
    logic [NSTG-1:0] vld_reg;

    // stage 1: input words
    logic [IN_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;

    // stage 2: edge magnitudes and cross term signs
    logic [IN_W:0]    ux_d, uy_d, vx_d, vy_d, wx_d, wy_d;
    logic [MAG_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic             pa_neg_reg, pb_neg_reg;

    // stages 3-4: squares and cross terms
    logic [PR_W-1:0] uxsq, uysq, vxsq, vysq, wxsq, wysq, pa, pb;
    logic [1:0]      sgn_d;

    // stage 5: squared sides, signed cross product
    logic [SQ_W-1:0]        s1_reg, s2_reg, s3_reg;
    logic signed [CR_W:0]   sa, sb;
    logic signed [CR_W:0]   cr_reg;

    // stage 6: magnitude and flags
    logic [SQ_W-1:0] s1b_reg, s2b_reg, s3b_reg;
    logic [CR_W:0]   cr_neg;
    logic [CR_W-1:0] crm_reg;
    cpc_flags_t      flg_reg;

    // stages 7-10
    logic [2*SQ_W-1:0] den12;
    logic [CRSQ_W-1:0] crsq, crsq_d;
    logic [SQ_W-1:0]   s3_d;
    logic [DEN_W-1:0]  den;
    cpc_flags_t        flg_d;

    // root cell row
    logic [CW-1:0]    r_c   [QB+1];
    logic [CW-1:0]    p_c   [QB+1];
    logic [QB-1:0]    q_c   [QB+1];
    logic [DEN_W-1:0] den_c [QB+1];
    cpc_flags_t       f_c   [QB+1];

    // final stage
    cpc_flags_t        fin;
    logic [QB-1:0]     q_fin, lim, q_clip;
    logic              sat_fin;
    logic [OUT_W-1:0]  mag_fin;
    logic [OUT_W-1:0]  curv_reg;
    logic              deg_reg, sat_reg;

    // output buffer
    logic              push, pop;
    logic              out_vld_reg, skid_vld_reg;
    logic [OUT_W-1:0]  out_curv_reg, skid_curv_reg;
    logic              out_deg_reg, skid_deg_reg;
    logic              out_sat_reg, skid_sat_reg;

    // the pipe only holds when the skid word is occupied
    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= first_x;
            y1_reg <= first_y;
            x2_reg <= second_x;
            y2_reg <= second_y;
            x3_reg <= third_x;
            y3_reg <= third_y;
        end
    end

    // ---- stage 2: u = p2-p1, v = p3-p1, w = p2-p3 ----
    assign ux_d = {x2_reg[IN_W-1], x2_reg} - {x1_reg[IN_W-1], x1_reg};
    assign uy_d = {y2_reg[IN_W-1], y2_reg} - {y1_reg[IN_W-1], y1_reg};
    assign vx_d = {x3_reg[IN_W-1], x3_reg} - {x1_reg[IN_W-1], x1_reg};
    assign vy_d = {y3_reg[IN_W-1], y3_reg} - {y1_reg[IN_W-1], y1_reg};
    assign wx_d = {x2_reg[IN_W-1], x2_reg} - {x3_reg[IN_W-1], x3_reg};
    assign wy_d = {y2_reg[IN_W-1], y2_reg} - {y3_reg[IN_W-1], y3_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg     <= mag_of(ux_d);
            uy_reg     <= mag_of(uy_d);
            vx_reg     <= mag_of(vx_d);
            vy_reg     <= mag_of(vy_d);
            wx_reg     <= mag_of(wx_d);
            wy_reg     <= mag_of(wy_d);
            // cross = ux*vy - vx*uy
            pa_neg_reg <= ux_d[IN_W] ^ vy_d[IN_W];
            pb_neg_reg <= !(vx_d[IN_W] ^ uy_d[IN_W]);
        end
    end

    // ---- stages 3-4 ----
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_uxsq
        (.clk(clk), .en(adv), .a(ux_reg), .b(ux_reg), .p(uxsq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_uysq
        (.clk(clk), .en(adv), .a(uy_reg), .b(uy_reg), .p(uysq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_vxsq
        (.clk(clk), .en(adv), .a(vx_reg), .b(vx_reg), .p(vxsq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_vysq
        (.clk(clk), .en(adv), .a(vy_reg), .b(vy_reg), .p(vysq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_wxsq
        (.clk(clk), .en(adv), .a(wx_reg), .b(wx_reg), .p(wxsq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_wysq
        (.clk(clk), .en(adv), .a(wy_reg), .b(wy_reg), .p(wysq));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pa
        (.clk(clk), .en(adv), .a(ux_reg), .b(vy_reg), .p(pa));
    cpc_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_pb
        (.clk(clk), .en(adv), .a(vx_reg), .b(uy_reg), .p(pb));

    cpc_dly #(.W(2), .N(2)) u_dly_sgn
        (.clk(clk), .en(adv), .d({pa_neg_reg, pb_neg_reg}), .q(sgn_d));

    // ---- stage 5 ----
    assign sa = sgn_d[1] ? -((CR_W+1)'(pa)) : (CR_W+1)'(pa);
    assign sb = sgn_d[0] ? -((CR_W+1)'(pb)) : (CR_W+1)'(pb);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= SQ_W'(uxsq) + SQ_W'(uysq);
            s2_reg <= SQ_W'(vxsq) + SQ_W'(vysq);
            s3_reg <= SQ_W'(wxsq) + SQ_W'(wysq);
            cr_reg <= sa + sb;
        end
    end

    // ---- stage 6 ----
    assign cr_neg = -cr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1b_reg     <= s1_reg;
            s2b_reg     <= s2_reg;
            s3b_reg     <= s3_reg;
            crm_reg     <= cr_reg[CR_W] ? cr_neg[CR_W-1:0] : cr_reg[CR_W-1:0];
            flg_reg.neg <= cr_reg[CR_W];
            flg_reg.deg <= (s1_reg == '0) || (s2_reg == '0) || (s3_reg == '0);
            flg_reg.crz <= (cr_reg == '0);
        end
    end

    // ---- stages 7-10: den = s1*s2*s3, cross squared ----
    cpc_mul #(.AW(SQ_W), .BW(SQ_W)) u_mul_den12
        (.clk(clk), .en(adv), .a(s1b_reg), .b(s2b_reg), .p(den12));
    cpc_mul #(.AW(CR_W), .BW(CR_W)) u_mul_crsq
        (.clk(clk), .en(adv), .a(crm_reg), .b(crm_reg), .p(crsq));
    cpc_dly #(.W(SQ_W), .N(2)) u_dly_s3
        (.clk(clk), .en(adv), .d(s3b_reg), .q(s3_d));

    cpc_mul #(.AW(2*SQ_W), .BW(SQ_W)) u_mul_den
        (.clk(clk), .en(adv), .a(den12), .b(s3_d), .p(den));
    cpc_dly #(.W(CRSQ_W), .N(2)) u_dly_crsq
        (.clk(clk), .en(adv), .d(crsq), .q(crsq_d));
    cpc_dly #(.W($bits(cpc_flags_t)), .N(4)) u_dly_flg
        (.clk(clk), .en(adv), .d(flg_reg), .q(flg_d));

    // ---- root cells: largest q with q^2*den <= num ----
    assign r_c[0]   = CW'(crsq_d) << SH;
    assign p_c[0]   = '0;
    assign q_c[0]   = '0;
    assign den_c[0] = den;
    assign f_c[0]   = flg_d;

    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        cpc_cell #(.BIT(QB - 1 - k), .CW(CW)) u_cell (
            .clk     (clk),
            .en      (adv),
            .r_in    (r_c[k]),
            .p_in    (p_c[k]),
            .q_in    (q_c[k]),
            .den_in  (den_c[k]),
            .flg_in  (f_c[k]),
            .r_out   (r_c[k+1]),
            .p_out   (p_c[k+1]),
            .q_out   (q_c[k+1]),
            .den_out (den_c[k+1]),
            .flg_out (f_c[k+1])
        );
    end

    // ---- final stage: clamp, sign, special cases ----
    assign fin     = f_c[QB];
    assign q_fin   = q_c[QB];
    assign lim     = fin.neg ? LIM_NEG : LIM_POS;
    assign sat_fin = (q_fin > lim);
    assign q_clip  = sat_fin ? lim : q_fin;
    assign mag_fin = q_clip[OUT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fin.deg)
            begin
                curv_reg <= '0;
                deg_reg  <= 1'b1;
                sat_reg  <= 1'b0;
            end
            else if (fin.crz)
            begin
                curv_reg <= '0;
                deg_reg  <= 1'b0;
                sat_reg  <= 1'b0;
            end
            else
            begin
                curv_reg <= fin.neg ? -mag_fin : mag_fin;
                deg_reg  <= 1'b0;
                sat_reg  <= sat_fin;
            end
        end
    end

    // ---- two-word output buffer ----
    assign push = adv && vld_reg[NSTG-1];
    assign pop  = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || pop)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || pop)
        begin
            if (skid_vld_reg)
            begin
                out_curv_reg <= skid_curv_reg;
                out_deg_reg  <= skid_deg_reg;
                out_sat_reg  <= skid_sat_reg;
            end
            else if (push)
            begin
                out_curv_reg <= curv_reg;
                out_deg_reg  <= deg_reg;
                out_sat_reg  <= sat_reg;
            end
        end
        else if (push)
        begin
            skid_curv_reg <= curv_reg;
            skid_deg_reg  <= deg_reg;
            skid_sat_reg  <= sat_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign curvature  = out_curv_reg;
    assign degenerate = out_deg_reg;
    assign saturated  = out_sat_reg;

endmodule

>>> hw/rtl/cpc_dly.sv
// ----------------------------------------------------------------------------
// cpc_dly: enabled delay line
// Carries side data alongside the multiplier stages.
// ----------------------------------------------------------------------------
module cpc_dly #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dly_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[N-1];

endmodule

>>> hw/rtl/cpc_mul.sv
// ----------------------------------------------------------------------------
// cpc_mul: two-stage unsigned multiplier
// 32-bit limb partial products registered, then summed and registered.
// ----------------------------------------------------------------------------
module cpc_mul import cpc_pkg::*; #(
    parameter int AW = 43,
    parameter int BW = 43
) (
    input  logic               clk,
    input  logic               en,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic [AW+BW-1:0]   p
);

    localparam int NA    = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB    = (BW + LIMB_W - 1) / LIMB_W;
    localparam int NP    = NA * NB;
    localparam int SUM_W = (NA + NB) * LIMB_W;

    logic [NA*LIMB_W-1:0] a_pad;
    logic [NB*LIMB_W-1:0] b_pad;
    logic [2*LIMB_W-1:0]  pp_reg [NP];
    logic [SUM_W-1:0]     sum;
    logic [AW+BW-1:0]     p_reg;

    assign a_pad = (NA*LIMB_W)'(a);
    assign b_pad = (NB*LIMB_W)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                                    * (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
                end
            end
            p_reg <= sum[AW+BW-1:0];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum = sum + (SUM_W'(pp_reg[i*NB+j]) << (LIMB_W * (i + j)));
            end
        end
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/cpc_cell.sv
// ----------------------------------------------------------------------------
// cpc_cell: one bit of the scaled square root
// Decides root bit BIT: keeps remainder r = num - q^2*den and p = q*den.
// ----------------------------------------------------------------------------
module cpc_cell import cpc_pkg::*; #(
    parameter int BIT = 0,
    parameter int CW  = 328
) (
    input  logic             clk,
    input  logic             en,
    input  logic [CW-1:0]    r_in,
    input  logic [CW-1:0]    p_in,
    input  logic [QB-1:0]    q_in,
    input  logic [DEN_W-1:0] den_in,
    input  cpc_flags_t       flg_in,
    output logic [CW-1:0]    r_out,
    output logic [CW-1:0]    p_out,
    output logic [QB-1:0]    q_out,
    output logic [DEN_W-1:0] den_out,
    output cpc_flags_t       flg_out
);

    logic [CW-1:0]    sub;
    logic             fits;
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    p_reg;
    logic [QB-1:0]    q_reg;
    logic [DEN_W-1:0] den_reg;
    cpc_flags_t       flg_reg;

    // (q + 2^b)^2*den - q^2*den = 2^(b+1)*p + 2^(2b)*den
    assign sub  = (p_in << (BIT + 1)) + (CW'(den_in) << (2 * BIT));
    assign fits = (r_in >= sub);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= fits ? (r_in - sub) : r_in;
            p_reg   <= fits ? (p_in + (CW'(den_in) << BIT)) : p_in;
            q_reg   <= q_in | (QB'(fits) << BIT);
            den_reg <= den_in;
            flg_reg <= flg_in;
        end
    end

    assign r_out   = r_reg;
    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;
    assign flg_out = flg_reg;

endmodule

>>> hw/rtl/cpc_chk.sv
// ----------------------------------------------------------------------------
// cpc_chk: port checker for the curvature core
// Output handshake and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module cpc_chk import cpc_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic signed [IN_W-1:0]  first_x,
    input logic signed [IN_W-1:0]  first_y,
    input logic signed [IN_W-1:0]  second_x,
    input logic signed [IN_W-1:0]  second_y,
    input logic signed [IN_W-1:0]  third_x,
    input logic signed [IN_W-1:0]  third_y,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] curvature,
    input logic                    degenerate,
    input logic                    saturated
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(curvature) && $stable(degenerate) && $stable(saturated))
        else $error("output word changed while stalled");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> (curvature == '0) && !saturated)
        else $error("degenerate word with nonzero curvature or saturation");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (curvature == 32'sh7FFF_FFFF) || (curvature == 32'sh8000_0000))
        else $error("saturated word not at a range bound");

endmodule

bind three_point_curvature_core cpc_chk u_cpc_chk (.*);
